/* hdl/glu_pkg.sv */
// Shared widths, sequencer states and status struct for the gcd/lcm unit.
`default_nettype none

package glu_pkg;

  // Operand width; the lcm result is twice as wide.
  localparam int DATA_WIDTH = 31;
  localparam int LCM_W      = 2 * DATA_WIDTH;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EUC_DIV,
    ST_EUC_NEXT,
    ST_Q_DIV,
    ST_MUL,
    ST_FIN
  } glu_state_t;

  // Status from the core to the handshake logic.
  typedef struct packed {
    logic busy;
    logic fin;
  } glu_status_t;

endpackage

`default_nettype wire

/* hdl/glu_addsub.sv */
// Shared double-width adder/subtractor used by every divide and multiply step.
`default_nettype none

module glu_addsub (
  input  wire logic [glu_pkg::LCM_W-1:0] op_a,
  input  wire logic [glu_pkg::LCM_W-1:0] op_b,
  input  wire logic                      sub,
  output logic      [glu_pkg::LCM_W-1:0] sum,
  output logic                           neg
);

  logic [glu_pkg::LCM_W:0] ext_a;
  logic [glu_pkg::LCM_W:0] ext_b;
  logic [glu_pkg::LCM_W:0] res;

  // Add, or subtract through inversion plus carry in.
  always_comb begin
    ext_a = {1'b0, op_a};
    ext_b = sub ? ~{1'b0, op_b} : {1'b0, op_b};
    res   = ext_a + ext_b + {{glu_pkg::LCM_W{1'b0}}, sub};
    sum   = res[glu_pkg::LCM_W-1:0];
    neg   = sub & res[glu_pkg::LCM_W];
  end

endmodule

`default_nettype wire

/* hdl/glu_core.sv */
// Sequencer and datapath registers: Euclid by restoring division, then a/g and shift-add multiply.
`default_nettype none

module glu_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [glu_pkg::DATA_WIDTH-1:0] opa,
  input  wire logic [glu_pkg::DATA_WIDTH-1:0] opb,
  input  wire logic                           take,
  output glu_pkg::glu_status_t                status,
  output logic      [glu_pkg::DATA_WIDTH-1:0] gcd_res,
  output logic      [glu_pkg::LCM_W-1:0]      lcm_res
);

  localparam int W = glu_pkg::DATA_WIDTH;
  localparam int L = glu_pkg::LCM_W;
  localparam logic [glu_pkg::CNT_W-1:0] LAST = glu_pkg::CNT_W'(W - 1);

  glu_pkg::glu_state_t state_r, state_nxt;

  logic [glu_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0] dvd_r, dvd_nxt;   // dividend shifting out, quotient shifting in
  logic [W-1:0] rem_r, rem_nxt;   // partial remainder
  logic [W-1:0] den_r, den_nxt;   // divisor
  logic [W-1:0] b_r, b_nxt;
  logic [W-1:0] a_r, a_nxt;
  logic [W-1:0] gcd_r, gcd_nxt;
  logic [W-1:0] m_r, m_nxt;       // multiplier bits, LSB first
  logic [L-1:0] mc_r, mc_nxt;     // shifted multiplicand
  logic [L-1:0] acc_r, acc_nxt;   // product accumulator

  logic [W:0]   shifted;
  logic [L-1:0] au_a, au_b, au_sum;
  logic         au_sub, au_neg;
  logic         qbit;
  logic [W-1:0] rem_step;
  logic [W-1:0] dvd_step;
  logic         div_state;

  glu_addsub u_addsub (
    .op_a (au_a),
    .op_b (au_b),
    .sub  (au_sub),
    .sum  (au_sum),
    .neg  (au_neg)
  );

  // Route the shared unit: trial subtract while dividing, add while multiplying.
  always_comb begin
    div_state = state_r inside {glu_pkg::ST_EUC_DIV, glu_pkg::ST_Q_DIV};
    shifted   = {rem_r, dvd_r[W-1]};
    if (div_state) begin
      au_a   = L'(shifted);
      au_b   = L'(den_r);
      au_sub = 1'b1;
    end else begin
      au_a   = acc_r;
      au_b   = m_r[0] ? mc_r : '0;
      au_sub = 1'b0;
    end
    qbit     = ~au_neg;
    rem_step = qbit ? au_sum[W-1:0] : shifted[W-1:0];
    dvd_step = {dvd_r[W-2:0], qbit};
  end

  // Hold state and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= glu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    gcd_r <= gcd_nxt;
    m_r   <= m_nxt;
    mc_r  <= mc_nxt;
    acc_r <= acc_nxt;
  end

  // Sequence: order pair, Euclid loop, divide a by gcd, multiply by b; a zero operand skips to finish.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    gcd_nxt   = gcd_r;
    m_nxt     = m_r;
    mc_nxt    = mc_r;
    acc_nxt   = acc_r;
    case (state_r)
      glu_pkg::ST_IDLE: begin
        if (start) begin
          a_nxt   = opa;
          b_nxt   = opb;
          cnt_nxt = '0;
          rem_nxt = '0;
          if ((opa == '0) || (opb == '0)) begin
            // one side zero: gcd is the other side, lcm is zero
            gcd_nxt   = opa | opb;
            acc_nxt   = '0;
            state_nxt = glu_pkg::ST_FIN;
          end else begin
            dvd_nxt   = (opa > opb) ? opa : opb;
            den_nxt   = (opa > opb) ? opb : opa;
            state_nxt = glu_pkg::ST_EUC_DIV;
          end
        end
      end
      glu_pkg::ST_EUC_DIV: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = glu_pkg::ST_EUC_NEXT;
        end
      end
      glu_pkg::ST_EUC_NEXT: begin
        cnt_nxt = '0;
        rem_nxt = '0;
        if (rem_r == '0) begin
          // divisor is the gcd; now form a / gcd
          gcd_nxt   = den_r;
          dvd_nxt   = a_r;
          state_nxt = glu_pkg::ST_Q_DIV;
        end else begin
          dvd_nxt   = den_r;
          den_nxt   = rem_r;
          state_nxt = glu_pkg::ST_EUC_DIV;
        end
      end
      glu_pkg::ST_Q_DIV: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          m_nxt     = dvd_step;
          mc_nxt    = L'(b_r);
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = glu_pkg::ST_MUL;
        end
      end
      glu_pkg::ST_MUL: begin
        acc_nxt = au_sum;
        m_nxt   = m_r >> 1;
        mc_nxt  = mc_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = glu_pkg::ST_FIN;
        end
      end
      glu_pkg::ST_FIN: begin
        if (take) begin
          state_nxt = glu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = glu_pkg::ST_IDLE;
      end
    endcase
  end

  // Report status and results.
  always_comb begin
    status.busy = (state_r != glu_pkg::ST_IDLE);
    status.fin  = (state_r == glu_pkg::ST_FIN);
    gcd_res     = gcd_r;
    lcm_res     = acc_r;
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == glu_pkg::ST_IDLE))
    else $error("item started while core busy");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == glu_pkg::ST_EUC_DIV || state_r == glu_pkg::ST_Q_DIV) |-> (den_r != '0))
    else $error("division by zero in core");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == glu_pkg::ST_EUC_NEXT) |-> (rem_r < den_r))
    else $error("remainder not below divisor");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == glu_pkg::ST_FIN && !take) |=> (state_r == glu_pkg::ST_FIN))
    else $error("result dropped before it was taken");
`endif

endmodule

`default_nettype wire

/* hdl/gcd_lcm_unit.sv */
// Top level of the gcd/lcm unit: input handshake, result register and core.
//
// Takes two unsigned operands and returns their greatest common divisor and
// their exact double-width least common multiple. One item is worked at a
// time through a single shared adder/subtractor: each Euclid remainder step is
// a restoring division, then a is divided by the gcd and the quotient is
// multiplied by b in a shift-add multiply. There are at most about 45 Euclid
// steps for 31-bit operands. An item with a zero operand skips the division
// and multiply steps and goes straight to the finished state. A finished
// result waits in an output register, so a new item is taken while the
// previous result is still stalled.
`default_nettype none

module gcd_lcm_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [glu_pkg::DATA_WIDTH-1:0] in_operand_a,
  input  wire logic [glu_pkg::DATA_WIDTH-1:0] in_operand_b,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [glu_pkg::DATA_WIDTH-1:0] out_gcd_value,
  output logic      [glu_pkg::LCM_W-1:0]      out_lcm_value
);

  glu_pkg::glu_status_t status;

  logic                           start;
  logic                           take;
  logic [glu_pkg::DATA_WIDTH-1:0] gcd_res;
  logic [glu_pkg::LCM_W-1:0]      lcm_res;
  logic                           out_valid_r, out_valid_nxt;
  logic [glu_pkg::DATA_WIDTH-1:0] out_gcd_r, out_gcd_nxt;
  logic [glu_pkg::LCM_W-1:0]      out_lcm_r, out_lcm_nxt;

  glu_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .opa     (in_operand_a),
    .opb     (in_operand_b),
    .take    (take),
    .status  (status),
    .gcd_res (gcd_res),
    .lcm_res (lcm_res)
  );

  // Accept an item only while the core is idle; move results when the slot frees.
  always_comb begin
    in_stall      = status.busy;
    start         = in_valid & ~status.busy;
    take          = status.fin & (~out_valid_r | ~out_stall);
    out_valid_nxt = out_valid_r;
    out_gcd_nxt   = out_gcd_r;
    out_lcm_nxt   = out_lcm_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      out_valid_nxt = 1'b1;
      out_gcd_nxt   = gcd_res;
      out_lcm_nxt   = lcm_res;
    end
  end

  // Hold the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_gcd_r <= out_gcd_nxt;
    out_lcm_r <= out_lcm_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_gcd_value = out_gcd_r;
  assign out_lcm_value = out_lcm_r;

endmodule

`default_nettype wire
